// ===== sv/adc_ts_pkg.sv =====
// Package for the ADC and touchscreen controller: transaction types, operation
// and register codes, reset values and the millivolt scaling constants.
// Depends on nothing; every other file of the block imports it.
package adc_ts_pkg;

   // Operation codes carried in a request transaction.
   localparam logic [2:0] OP_READ  = 3'd0;
   localparam logic [2:0] OP_WRITE = 3'd1;
   localparam logic [2:0] OP_TICK  = 3'd2;
   localparam logic [2:0] OP_PEN   = 3'd3;
   localparam logic [2:0] OP_AUX   = 3'd4;

   // Register word indexes (byte offset divided by four).
   localparam logic [2:0] REG_CONTROL = 3'd0;
   localparam logic [2:0] REG_TOUCH   = 3'd1;
   localparam logic [2:0] REG_DELAY   = 3'd2;
   localparam logic [2:0] REG_RESULT0 = 3'd3;
   localparam logic [2:0] REG_RESULT1 = 3'd4;
   localparam logic [2:0] REG_UPDOWN  = 3'd5;

   // Accepted access sizes and the first offset past the register map.
   localparam logic [2:0] SIZE_HALF = 3'd2;
   localparam logic [2:0] SIZE_WORD = 3'd4;
   localparam logic [4:0] MAP_END   = 5'h18;

   // Touch control modes (low two bits).
   localparam logic [1:0] MODE_X = 2'd1;
   localparam logic [1:0] MODE_Y = 2'd2;

   // Register widths and reset values.
   localparam int CONTROL_W = 15;
   localparam int TOUCH_W   = 9;
   localparam int DELAY_W   = 8;
   localparam int CODE_W    = 10;
   localparam int TAG_W     = 3;

   localparam logic [CONTROL_W-1:0] CONTROL_RESET = 15'h3fc4;
   localparam logic [TOUCH_W-1:0]   TOUCH_RESET   = 9'h058;
   localparam logic [DELAY_W-1:0]   DELAY_RESET   = 8'hff;

   // Control and touch control bit positions.
   localparam int CTRL_STANDBY_BIT = 2;
   localparam int CTRL_SEL_LSB     = 3;
   localparam int TOUCH_BOTH_BIT   = 2;
   localparam int TOUCH_UP_BIT     = 8;

   // Millivolt to 10-bit code: (mv * 1024 + 1650) / 3300. The quotient is
   // first estimated by a reciprocal multiply (at most one short), then fixed.
   localparam int unsigned SCALE_DIVISOR = 3300;
   localparam int unsigned SCALE_ROUND   = SCALE_DIVISOR / 2;
   localparam int unsigned SCALE_SHIFT   = 27;
   localparam int unsigned SCALE_RECIP   = (1 << SCALE_SHIFT) / SCALE_DIVISOR;

   // Request transaction.
   typedef struct packed {
      logic [2:0]         op;
      logic [4:0]         reg_offset;
      logic [2:0]         access_bytes;
      logic [15:0]        write_data;
      logic signed [15:0] pen_x;
      logic signed [15:0] pen_y;
      logic [3:0]         aux_channel;
      logic [15:0]        aux_millivolts;
   } req_item_type;

   // Response transaction.
   typedef struct packed {
      logic [15:0] read_data;
      logic        access_ok;
      logic        conversion_irq;
      logic        touch_irq;
      logic        start_while_busy;
   } rsp_item_type;

endpackage

// ===== sv/adc_ts_req_if.sv =====
// Request channel interface of the ADC and touchscreen controller.
// Depends on adc_ts_pkg for the request transaction type.
interface adc_ts_req_if;
   import adc_ts_pkg::*;

   logic         valid;
   logic         ready;
   req_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/adc_ts_rsp_if.sv =====
// Response channel interface of the ADC and touchscreen controller.
// Depends on adc_ts_pkg for the response transaction type.
interface adc_ts_rsp_if;
   import adc_ts_pkg::*;

   logic         valid;
   logic         ready;
   rsp_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/adc_touchscreen_controller.sv =====
// Top level of the ADC and touchscreen controller: register map, conversion
// countdown, pen tracking and the response register.
// Depends on adc_ts_pkg, adc_ts_req_if, adc_ts_rsp_if and adc_ts_scale.
//
//   Channel    Direction  Transaction
//   req_chan   in         bus read/write, tick, pen position or aux voltage
//   rsp_chan   out        read data, access status and interrupt pulses
//
// One transaction is taken every cycle while responses are taken; its response
// passes the input register, then the response register, before it is offered.
// The throughput is set by the single execute step between those two
// registers, which holds the reciprocal correction of the voltage scaler.
// Reset is synchronous and restores the valid flags and the architectural state to their power-on values.
// A stalled response holds its register; the input register then fills and
// req_chan.ready falls until the response is taken.
module adc_touchscreen_controller #(
   parameter int AUX_CHANNELS     = 8,
   parameter int CONVERSION_TICKS = 3
) (
   input  logic          clock,
   input  logic          reset,
   adc_ts_req_if.sink    req_chan,
   adc_ts_rsp_if.source  rsp_chan
);
   import adc_ts_pkg::*;

   localparam int BUSY_W    = $clog2(CONVERSION_TICKS + 1);
   localparam int AUX_IDX_W = (AUX_CHANNELS > 1) ? $clog2(AUX_CHANNELS) : 1;

   // Handshake and pipeline control.
   logic         item_valid_ff, item_valid_in;
   req_item_type item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff, rsp_in;
   logic         out_free, execute, load;

   // Architectural state.
   logic [CONTROL_W-1:0] control_ff, control_in;
   logic [TOUCH_W-1:0]   touch_ff, touch_in;
   logic [DELAY_W-1:0]   delay_ff, delay_in;
   logic [1:0]           updown_ff, updown_in;
   logic [CODE_W-1:0]    res_code_ff [2];
   logic [CODE_W-1:0]    res_code_in [2];
   logic [TAG_W-1:0]     res_tag_ff [2];
   logic [TAG_W-1:0]     res_tag_in [2];
   logic [BUSY_W-1:0]    busy_ff, busy_in;
   logic [1:0]           ready_ff, ready_in;
   logic                 pen_down_ff, pen_down_in;
   logic                 last_pen_ff, last_pen_in;
   logic [CODE_W-1:0]    pen_x_ff, pen_x_in;
   logic [CODE_W-1:0]    pen_y_ff, pen_y_in;
   logic [CODE_W-1:0]    aux_ff [AUX_CHANNELS];
   logic [CODE_W-1:0]    aux_in [AUX_CHANNELS];

   // Execute step working values.
   logic [CODE_W-1:0]    aux_code;
   logic [2:0]           word;
   logic                 bad_access;
   logic [2:0]           aux_sel;
   logic                 pen_down_now;

   // Flow control: the response register frees the execute step.
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign execute        = item_valid_ff && out_free;
   assign req_chan.ready = !item_valid_ff || execute;
   assign load           = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   // Voltage scaler, loaded together with the input register.
   adc_ts_scale u_scale (
      .clock      (clock),
      .load       (load),
      .millivolts (req_chan.payload.aux_millivolts),
      .code       (aux_code)
   );

   // Execute step: decode the held transaction, form the response and the
   // next state.
   always_comb begin
      control_in  = control_ff;
      touch_in    = touch_ff;
      delay_in    = delay_ff;
      updown_in   = updown_ff;
      res_code_in = res_code_ff;
      res_tag_in  = res_tag_ff;
      busy_in     = busy_ff;
      ready_in    = ready_ff;
      pen_down_in = pen_down_ff;
      last_pen_in = last_pen_ff;
      pen_x_in    = pen_x_ff;
      pen_y_in    = pen_y_ff;
      aux_in      = aux_ff;
      rsp_in      = '0;

      word       = item_ff.reg_offset[4:2];
      bad_access = (item_ff.access_bytes != SIZE_HALF && item_ff.access_bytes != SIZE_WORD)
                   || (item_ff.reg_offset[1:0] != 2'b00)
                   || (item_ff.reg_offset >= MAP_END)
                   || (item_ff.op == OP_WRITE
                       && (word == REG_RESULT0 || word == REG_RESULT1));
      aux_sel      = control_ff[CTRL_SEL_LSB +: 3];
      pen_down_now = !item_ff.pen_x[15] && !item_ff.pen_y[15];

      unique case (item_ff.op) inside
         OP_READ, OP_WRITE: begin
            if (!bad_access) begin
               rsp_in.access_ok = 1'b1;
               unique case (word) inside
                  REG_CONTROL: begin
                     if (item_ff.op == OP_WRITE) begin
                        control_in = {item_ff.write_data[CONTROL_W-1:1], 1'b0};
                        if (item_ff.write_data[0]) begin
                           rsp_in.start_while_busy = (busy_ff != '0);
                           busy_in = BUSY_W'(CONVERSION_TICKS);
                        end
                     end else begin
                        rsp_in.read_data = {(ready_ff != 2'b00), control_ff};
                     end
                  end
                  REG_TOUCH: begin
                     if (item_ff.op == OP_WRITE) begin
                        touch_in = item_ff.write_data[TOUCH_W-1:0];
                     end else begin
                        rsp_in.read_data = 16'(touch_ff);
                     end
                  end
                  REG_DELAY: begin
                     if (item_ff.op == OP_WRITE) begin
                        delay_in = item_ff.write_data[DELAY_W-1:0];
                     end else begin
                        rsp_in.read_data = 16'(delay_ff);
                     end
                  end
                  REG_RESULT0, REG_RESULT1: begin
                     // Reading a result word clears its data-ready flag.
                     rsp_in.read_data = {!pen_down_ff, res_tag_ff[word[0] ^ 1'b1], 2'b00,
                                         res_code_ff[word[0] ^ 1'b1]};
                     ready_in[word[0] ^ 1'b1] = 1'b0;
                  end
                  REG_UPDOWN: begin
                     if (item_ff.op == OP_WRITE) begin
                        updown_in = item_ff.write_data[1:0];
                     end else begin
                        rsp_in.read_data = 16'(updown_ff);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         OP_TICK: begin
            // Standby freezes the tick entirely.
            if (!control_ff[CTRL_STANDBY_BIT]) begin
               if (touch_ff[TOUCH_UP_BIT] && !pen_down_ff) begin
                  updown_in[1] = 1'b1;
               end else if (!touch_ff[TOUCH_UP_BIT] && pen_down_ff) begin
                  updown_in[0] = 1'b1;
               end
               if (busy_ff != '0) begin
                  busy_in = busy_ff - BUSY_W'(1);
                  if (busy_ff == BUSY_W'(1)) begin
                     // Conversion complete: the mode picks what is stored.
                     rsp_in.conversion_irq = 1'b1;
                     if (touch_ff[1:0] == MODE_X) begin
                        res_code_in[0] = pen_x_ff;
                        res_tag_in[0]  = touch_ff[TAG_W-1:0];
                        ready_in[0]    = 1'b1;
                     end else if (touch_ff[1:0] == MODE_Y) begin
                        res_code_in[1] = pen_y_ff;
                        res_tag_in[1]  = touch_ff[TAG_W-1:0];
                        ready_in[1]    = 1'b1;
                     end else if (touch_ff[TOUCH_BOTH_BIT]) begin
                        res_code_in[0] = pen_x_ff;
                        res_code_in[1] = pen_y_ff;
                        res_tag_in[0]  = touch_ff[TAG_W-1:0];
                        res_tag_in[1]  = touch_ff[TAG_W-1:0];
                        ready_in       = 2'b11;
                     end else begin
                        // An auxiliary select beyond the fitted channels reads zero.
                        if ({1'b0, aux_sel} < 4'(AUX_CHANNELS)) begin
                           res_code_in[0] = aux_ff[aux_sel[AUX_IDX_W-1:0]];
                        end else begin
                           res_code_in[0] = '0;
                        end
                        res_tag_in[0] = touch_ff[TAG_W-1:0];
                        ready_in[0]   = 1'b1;
                     end
                  end
               end
            end
         end
         OP_PEN: begin
            pen_down_in = pen_down_now;
            pen_x_in    = item_ff.pen_x[CODE_W-1:0];
            pen_y_in    = item_ff.pen_y[CODE_W-1:0];
            // Report a change only in the direction being watched.
            if ((last_pen_ff != pen_down_now) && (touch_ff[1:0] != 2'b00)
                && (touch_ff[TOUCH_UP_BIT] == last_pen_ff)) begin
               rsp_in.touch_irq = 1'b1;
               last_pen_in      = pen_down_now;
            end
         end
         OP_AUX: begin
            if (item_ff.aux_channel < 4'(AUX_CHANNELS)) begin
               aux_in[item_ff.aux_channel[AUX_IDX_W-1:0]] = aux_code;
            end
         end
         default: begin
         end
      endcase
   end

   // Handshake valid flags.
   always_comb begin
      if (load) begin
         item_valid_in = 1'b1;
      end else if (execute) begin
         item_valid_in = 1'b0;
      end else begin
         item_valid_in = item_valid_ff;
      end
      if (execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_chan.payload;
      end
      if (execute) begin
         rsp_ff <= rsp_in;
      end
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         control_ff    <= CONTROL_RESET;
         touch_ff      <= TOUCH_RESET;
         delay_ff      <= DELAY_RESET;
         updown_ff     <= '0;
         res_code_ff   <= '{default: '0};
         res_tag_ff    <= '{default: '0};
         busy_ff       <= '0;
         ready_ff      <= '0;
         pen_down_ff   <= 1'b0;
         last_pen_ff   <= 1'b0;
         pen_x_ff      <= '0;
         pen_y_ff      <= '0;
         aux_ff        <= '{default: '0};
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (execute) begin
            control_ff  <= control_in;
            touch_ff    <= touch_in;
            delay_ff    <= delay_in;
            updown_ff   <= updown_in;
            res_code_ff <= res_code_in;
            res_tag_ff  <= res_tag_in;
            busy_ff     <= busy_in;
            ready_ff    <= ready_in;
            pen_down_ff <= pen_down_in;
            last_pen_ff <= last_pen_in;
            pen_x_ff    <= pen_x_in;
            pen_y_ff    <= pen_y_in;
            aux_ff      <= aux_in;
         end
      end
   end

`ifndef SYNTHESIS
   // A response carries at most one kind of event.
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_ff.access_ok, rsp_ff.conversion_irq, rsp_ff.touch_irq}))
      else $error("response flags more than one kind of event");

   // Read data and the busy error only come with an accepted bus access.
   a_data_needs_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.read_data != '0 || rsp_ff.start_while_busy)
      |-> rsp_ff.access_ok)
      else $error("read data or busy error without an accepted access");

   // The countdown never exceeds its armed length.
   a_busy_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff <= BUSY_W'(CONVERSION_TICKS))
      else $error("conversion countdown out of range");

   // A completed conversion leaves at least one result word flagged ready.
   a_irq_sets_ready: assert property (@(posedge clock) disable iff (reset)
      execute && rsp_in.conversion_irq |=> ready_ff != 2'b00)
      else $error("conversion completed without a ready result");
`endif

endmodule

// ===== sv/adc_ts_scale.sv =====
// Two-step millivolt to 10-bit code scaler: reciprocal multiply at load,
// remainder correction on the registered estimate. Depends on adc_ts_pkg.
module adc_ts_scale (
   input  logic                         clock,
   input  logic                         load,
   input  logic [15:0]                  millivolts,
   output logic [adc_ts_pkg::CODE_W-1:0] code
);
   import adc_ts_pkg::*;

   // Only the low bits of the quotient and numerator are kept: the true
   // remainder lies below twice the divisor, so 13 bits recover it exactly.
   localparam int LO_W = 13;

   logic [26:0]     numerator;
   logic [42:0]     product;
   logic [LO_W-1:0] quot_lo_ff, quot_lo_in;
   logic [LO_W-1:0] num_lo_ff, num_lo_in;
   logic [LO_W-1:0] quot_times_div;
   logic [LO_W-1:0] remainder;

   // Rounded numerator and the reciprocal estimate of the quotient.
   always_comb begin
      numerator  = {11'd0, millivolts} * 27'd1024 + 27'(SCALE_ROUND);
      product    = 43'(numerator) * 43'(SCALE_RECIP);
      quot_lo_in = product[SCALE_SHIFT + LO_W - 1 : SCALE_SHIFT];
      num_lo_in  = numerator[LO_W-1:0];
   end

   // The estimate travels alongside the transaction in the input register.
   always_ff @(posedge clock) begin
      if (load) begin
         quot_lo_ff <= quot_lo_in;
         num_lo_ff  <= num_lo_in;
      end
   end

   // Add one where the remainder still holds a whole divisor.
   always_comb begin
      quot_times_div = LO_W'(quot_lo_ff * LO_W'(SCALE_DIVISOR));
      remainder      = num_lo_ff - quot_times_div;
      code           = quot_lo_ff[CODE_W-1:0]
                       + CODE_W'(remainder >= LO_W'(SCALE_DIVISOR));
   end

endmodule
